>>> hdl/bia_pkg.sv
package bia_pkg;

    localparam int NUM_IDS   = 1024;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = NUM_IDS / WORD_W;
    localparam int RAW_W     = $clog2(NUM_IDS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WA_W      = $clog2(NUM_WORDS);

    localparam int KIND_W  = 2;
    localparam int ID_W    = 11;
    localparam int BLK_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NORES  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADARG = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   ident;
        logic [BLK_W-1:0]  block_num;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    new_ident;
        logic [BLK_W-1:0]   found_block;
        logic [COUNT_W-1:0] free_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic rd;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic slot;
    } t_sts;

endpackage

>>> hdl/bitmap_id_allocator_with_map.sv
// Steps: a look up reads the map entry and a free goes straight to the finish
// state; an allocate first scans the bitmap, one word of 32 per cycle.
// One item in flight: the input stalls until the finish state has loaded the
// result register, which waits for room at the output when it is stalled.
// Reset: bitmap cleared and free count set to the id total at once; the map
// table needs no clearing pass, as an entry is used only when its bit is set.
module bitmap_id_allocator_with_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bia_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bia_pkg::t_out_item o_out_data
);

    bia_pkg::t_cmd cmd;
    bia_pkg::t_sts sts;

    bia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bia_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/bia_ctrl.sv
module bia_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [bia_pkg::KIND_W-1:0]    i_in_kind,
    input  bia_pkg::t_sts                 i_sts,
    output logic                          o_in_stall,
    output bia_pkg::t_cmd                 o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_in_kind)
                        bia_pkg::KIND_ALLOC:  n_state = S_SCAN;
                        bia_pkg::KIND_LOOKUP: n_state = S_READ;
                        default:              n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.last) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_sts.slot) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/bia_dpath.sv
module bia_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bia_pkg::t_in_item     i_in_data,
    input  bia_pkg::t_cmd         i_cmd,
    input  logic                  i_out_stall,
    output bia_pkg::t_sts         o_sts,
    output logic                  o_out_valid,
    output bia_pkg::t_out_item    o_out_data
);

    logic [bia_pkg::KIND_W-1:0]  r_kind;
    logic [bia_pkg::ID_W-1:0]    r_ident;
    logic [bia_pkg::BLK_W-1:0]   r_blk;
    logic [bia_pkg::WA_W-1:0]    r_cnt;
    logic [bia_pkg::BIT_W-1:0]   r_bit;
    logic                        r_found;
    logic [bia_pkg::COUNT_W-1:0] r_free;
    logic [bia_pkg::WORD_W-1:0]  r_bitmap [bia_pkg::NUM_WORDS];
    logic [bia_pkg::BLK_W-1:0]   r_map [bia_pkg::NUM_IDS];
    logic [bia_pkg::BLK_W-1:0]   r_rd_data;
    logic                        r_out_valid;
    bia_pkg::t_out_item          r_out;

    logic [bia_pkg::ID_W-1:0]    id_m1;
    logic [bia_pkg::RAW_W-1:0]   idx_m1;
    logic [bia_pkg::RAW_W-1:0]   raw;
    logic [bia_pkg::WA_W-1:0]    word_addr;
    logic [bia_pkg::BIT_W-1:0]   bit_addr;
    logic [bia_pkg::WORD_W-1:0]  cur_word;
    logic                        cur_bit;
    logic                        hit;
    logic [bia_pkg::BIT_W-1:0]   hit_pos;
    logic                        slot;
    logic                        bm_we;
    logic                        bm_val;
    logic                        map_we;
    logic [bia_pkg::COUNT_W-1:0] n_free;
    bia_pkg::t_out_item          res;

    assign id_m1     = r_ident - bia_pkg::ID_W'(1);
    assign idx_m1    = id_m1[bia_pkg::RAW_W-1:0];
    assign raw       = {r_cnt, r_bit};
    assign word_addr = (r_kind == bia_pkg::KIND_ALLOC) ? r_cnt
                                                       : idx_m1[bia_pkg::RAW_W-1:bia_pkg::BIT_W];
    assign bit_addr  = (r_kind == bia_pkg::KIND_ALLOC) ? r_bit
                                                       : idx_m1[bia_pkg::BIT_W-1:0];
    assign cur_word  = r_bitmap[word_addr];
    assign cur_bit   = cur_word[bit_addr];
    assign hit       = ~&cur_word;
    assign slot      = !r_out_valid || !i_out_stall;

    // lowest clear bit of the word under scan
    always_comb begin
        hit_pos = '0;
        for (int i = bia_pkg::WORD_W - 1; i >= 0; i--) begin
            if (!cur_word[i]) begin
                hit_pos = bia_pkg::BIT_W'(i);
            end
        end
    end

    assign o_sts.hit  = hit;
    assign o_sts.last = (r_cnt == bia_pkg::WA_W'(bia_pkg::NUM_WORDS - 1));
    assign o_sts.slot = slot;

    always_comb begin
        res             = '0;
        res.status      = bia_pkg::ST_OK;
        bm_we           = 1'b0;
        bm_val          = 1'b0;
        map_we          = 1'b0;
        n_free          = r_free;
        case (r_kind)
            bia_pkg::KIND_ALLOC: begin
                if (!r_found) begin
                    res.status = bia_pkg::ST_NORES;
                end else begin
                    bm_we  = 1'b1;
                    bm_val = 1'b1;
                    n_free = r_free - bia_pkg::COUNT_W'(1);
                    if (raw >= bia_pkg::RAW_W'(bia_pkg::NUM_IDS - 2)) begin
                        res.status = bia_pkg::ST_NORES;
                    end else begin
                        map_we        = 1'b1;
                        res.new_ident = bia_pkg::ID_W'(raw) + bia_pkg::ID_W'(1);
                    end
                end
            end
            bia_pkg::KIND_LOOKUP: begin
                if (r_ident == '0) begin
                    res.status = bia_pkg::ST_BADARG;
                end else if (r_ident >= bia_pkg::ID_W'(bia_pkg::NUM_IDS - 1)) begin
                    res.status = bia_pkg::ST_NORES;
                end else begin
                    // entries never written since reset have a clear used bit
                    res.found_block = cur_bit ? r_rd_data : '0;
                end
            end
            bia_pkg::KIND_FREE: begin
                if (r_ident == '0 || r_ident >= bia_pkg::ID_W'(bia_pkg::NUM_IDS - 1)) begin
                    res.status = bia_pkg::ST_BADARG;
                end else if (cur_bit) begin
                    bm_we  = 1'b1;
                    n_free = r_free + bia_pkg::COUNT_W'(1);
                end
            end
            default: res.status = bia_pkg::ST_BADARG;
        endcase
        res.free_count = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_data.kind;
            r_ident <= i_in_data.ident;
            r_blk   <= i_in_data.block_num;
        end
        if (i_cmd.scan && hit) begin
            r_bit <= hit_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (hit) begin
                r_found <= 1'b1;
            end else if (!o_sts.last) begin
                r_cnt <= r_cnt + bia_pkg::WA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= bia_pkg::COUNT_W'(bia_pkg::NUM_IDS);
            for (int w = 0; w < bia_pkg::NUM_WORDS; w++) begin
                r_bitmap[w] <= '0;
            end
        end else if (i_cmd.fin) begin
            r_free <= n_free;
            if (bm_we) begin
                r_bitmap[word_addr][bit_addr] <= bm_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin && map_we) begin
            r_map[raw] <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_map[idx_m1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> dv/bitmap_id_allocator_with_map_tb.sv
module bitmap_id_allocator_with_map_tb;

    localparam logic [bia_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 160;
    localparam int HOLD_AT_BEAT = 300;

    class id_alloc_scoreboard;
        bit                         used_map  [bia_pkg::NUM_IDS];
        logic [bia_pkg::BLK_W-1:0]  block_map [bia_pkg::NUM_IDS];
        int                         free_ids;
        int                         top_ident;
        bia_pkg::t_out_item         expected_replies [$];
        int                         errors;
        int                         requests;
        int                         replies;
        int                         ok_cnt;
        int                         nores_cnt;
        int                         badarg_cnt;
        int                         full_hits;

        function new();
            foreach (used_map[i]) begin
                used_map[i]  = 1'b0;
                block_map[i] = '0;
            end
            free_ids   = bia_pkg::NUM_IDS;
            top_ident  = 1;
            errors     = 0;
            requests   = 0;
            replies    = 0;
            ok_cnt     = 0;
            nores_cnt  = 0;
            badarg_cnt = 0;
            full_hits  = 0;
        endfunction

        function bia_pkg::t_out_item model_request(bia_pkg::t_in_item req);
            bia_pkg::t_out_item rsp;
            int                 raw;
            bit                 found;
            rsp   = '0;
            raw   = 0;
            found = 1'b0;
            case (req.kind)
                bia_pkg::KIND_ALLOC: begin
                    for (int i = 0; i < bia_pkg::NUM_IDS && !found; i++) begin
                        if (!used_map[i]) begin
                            raw   = i;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        rsp.status = bia_pkg::ST_NORES;
                        full_hits++;
                    end else begin
                        used_map[raw] = 1'b1;
                        free_ids--;
                        if (raw >= bia_pkg::NUM_IDS - 2) begin
                            rsp.status = bia_pkg::ST_NORES;
                        end else begin
                            block_map[raw] = req.block_num;
                            rsp.status     = bia_pkg::ST_OK;
                            rsp.new_ident  = bia_pkg::ID_W'(raw + 1);
                            if (raw + 1 > top_ident) top_ident = raw + 1;
                        end
                    end
                end
                bia_pkg::KIND_LOOKUP: begin
                    if (req.ident == '0) begin
                        rsp.status = bia_pkg::ST_BADARG;
                    end else if (int'(req.ident) >= bia_pkg::NUM_IDS - 1) begin
                        rsp.status = bia_pkg::ST_NORES;
                    end else begin
                        rsp.status      = bia_pkg::ST_OK;
                        rsp.found_block = block_map[int'(req.ident) - 1];
                    end
                end
                bia_pkg::KIND_FREE: begin
                    if (req.ident == '0 || int'(req.ident) >= bia_pkg::NUM_IDS - 1) begin
                        rsp.status = bia_pkg::ST_BADARG;
                    end else begin
                        raw            = int'(req.ident) - 1;
                        block_map[raw] = '0;
                        if (used_map[raw]) begin
                            used_map[raw] = 1'b0;
                            free_ids++;
                        end
                        rsp.status = bia_pkg::ST_OK;
                    end
                end
                default: begin
                    rsp.status = bia_pkg::ST_BADARG;
                end
            endcase
            rsp.free_count = bia_pkg::COUNT_W'(free_ids);
            return rsp;
        endfunction

        function void note_request(bia_pkg::t_in_item req);
            bia_pkg::t_out_item rsp;
            rsp = model_request(req);
            expected_replies.push_back(rsp);
            requests++;
            if (rsp.status == bia_pkg::ST_OK) ok_cnt++;
            else if (rsp.status == bia_pkg::ST_NORES) nores_cnt++;
            else badarg_cnt++;
        endfunction

        function void compare_field(string name, logic [bia_pkg::BLK_W-1:0] want_v,
                                    logic [bia_pkg::BLK_W-1:0] got_v);
            if (want_v !== got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_response(bia_pkg::t_out_item got);
            bia_pkg::t_out_item want;
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: reply with none pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_replies.pop_front();
            replies++;
            compare_field("status", want.status, got.status);
            compare_field("new_ident", want.new_ident, got.new_ident);
            compare_field("found_block", want.found_block, got.found_block);
            compare_field("free_count", want.free_count, got.free_count);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    bia_pkg::t_in_item  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    bia_pkg::t_out_item out_data;

    int sent     = 0;
    int rx_beats = 0;

    id_alloc_scoreboard sb = new();

    bitmap_id_allocator_with_map i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            sb.check_response(out_data);
        end
    end

    function automatic bia_pkg::t_in_item mk_req(logic [bia_pkg::KIND_W-1:0] kind,
                                                 int ident,
                                                 logic [bia_pkg::BLK_W-1:0] blk);
        bia_pkg::t_in_item req;
        req.kind      = kind;
        req.ident     = bia_pkg::ID_W'(ident);
        req.block_num = blk;
        return req;
    endfunction

    function automatic logic [bia_pkg::ID_W-1:0] pick_ident();
        if ($urandom_range(0, 4) != 0) begin
            return bia_pkg::ID_W'($urandom_range(1, sb.top_ident));
        end
        return bia_pkg::ID_W'($urandom_range(0, bia_pkg::NUM_IDS));
    endfunction

    function automatic bia_pkg::t_in_item pick_request(int p_alloc, int p_lookup,
                                                       int p_free);
        bia_pkg::t_in_item req;
        int                r;
        r             = $urandom_range(0, 99);
        req.block_num = $urandom;
        req.ident     = pick_ident();
        if (r < p_alloc) begin
            req.kind = bia_pkg::KIND_ALLOC;
        end else if (r < p_alloc + p_lookup) begin
            req.kind = bia_pkg::KIND_LOOKUP;
        end else if (r < p_alloc + p_lookup + p_free) begin
            req.kind = bia_pkg::KIND_FREE;
        end else begin
            // stray kind, or an ident on the edge of the legal range
            if ($urandom_range(0, 1) != 0) req.kind = KIND_UNUSED;
            else if ($urandom_range(0, 1) != 0) req.kind = bia_pkg::KIND_LOOKUP;
            else req.kind = bia_pkg::KIND_FREE;
            case ($urandom_range(0, 2))
                0:       req.ident = '0;
                1:       req.ident = bia_pkg::ID_W'(bia_pkg::NUM_IDS - 1);
                default: req.ident = bia_pkg::ID_W'(bia_pkg::NUM_IDS);
            endcase
        end
        return req;
    endfunction

    task automatic send_item(bia_pkg::t_in_item req);
        int gap;
        gap = (((sent / 50) % 5) == 4) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_request(req);
        sent++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 0, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, 0, 32'hFFFF_FFFF));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 1, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, 5, 32'h0));
        send_item(mk_req(KIND_UNUSED, bia_pkg::NUM_IDS, 32'hFFFF_FFFF));
        send_item(mk_req(bia_pkg::KIND_ALLOC, 0, 32'h0000_0000));
        send_item(mk_req(bia_pkg::KIND_ALLOC, bia_pkg::NUM_IDS, 32'hFFFF_FFFF));
        send_item(mk_req(bia_pkg::KIND_ALLOC, bia_pkg::NUM_IDS - 1, 32'hA5A5_A5A5));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 1, 32'h0));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 2, 32'hFFFF_FFFF));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 3, 32'h0));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, bia_pkg::NUM_IDS - 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, bia_pkg::NUM_IDS - 1, 32'h0));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, bia_pkg::NUM_IDS, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, bia_pkg::NUM_IDS - 1, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, bia_pkg::NUM_IDS, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, bia_pkg::NUM_IDS - 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_ALLOC, 0, 32'h5A5A_5A5A));
        send_item(mk_req(bia_pkg::KIND_LOOKUP, 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, 2, 32'h0));
        send_item(mk_req(bia_pkg::KIND_FREE, 2, 32'h0));
        send_item(mk_req(KIND_UNUSED, 0, 32'h0));
    endtask

    // receive side; one long hold-off to back the block up
    initial begin
        int w;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_beats == HOLD_AT_BEAT) w = HOLD_CYCLES;
            else if (((rx_beats / 70) % 4) == 3) w = 0;
            else w = $urandom_range(0, 6);
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            rx_beats++;
            @(negedge clk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0)) idle = 0;
            else idle++;
        end
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        bia_pkg::t_in_item req;
        int                extra;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // fill the bitmap to the top, then knock on it while full
        extra = 0;
        while (extra < 6) begin
            req = pick_request(94, 3, 2);
            if (sb.free_ids == 0 && req.kind == bia_pkg::KIND_ALLOC) extra++;
            send_item(req);
        end

        repeat (40) send_item(pick_request(35, 30, 30));

        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests, %0d replies checked: %0d ok, %0d no res, %0d bad arg",
                 sb.requests, sb.replies, sb.ok_cnt, sb.nores_cnt, sb.badarg_cnt);
        $display("Bitmap driven to full (%0d allocs refused while full), one long output hold",
                 sb.full_hits);
        if (sb.errors == 0 && sb.expected_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
